// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the hash table block.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/ikht_pkg.sv =====
// Package of the integer-key chained hash table: operation and status codes
// and the fixed constants of the hash. No dependencies.
package ikht_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   localparam int          CFG_W              = 7;
   localparam int          KEY_W              = 32;
   localparam int          HASH_BITS          = 28;
   localparam logic [31:0] ELF_HIGH_MASK      = 32'hF000_0000;
   localparam int          ELF_FOLD_SHIFT     = 24;
   localparam logic [6:0]  BUCKET_COUNT_RESET = 7'd31;

endpackage

// ===== sv/ikht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ikht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/int_key_chained_hash_table_core.sv =====
// Top level of the integer-key chained hash table; uses ikht_pkg and
// instances of ikht_ram for the chain heads, the node fields and the free stack.
//
// The block keeps a separately chained hash table of 32-bit signed keys with
// a data word each. An operation (insert, lookup, delete) is taken as one
// request transfer and answered by exactly one response transfer carrying a
// status and, for a found lookup, the stored data. The bucket is the ELF hash
// of the key's bytes, lowest first and sign-extended, reduced modulo the
// configured bucket count (0 acts as 1, values above MAX_BUCKETS act as
// MAX_BUCKETS). A small sequencer does the work: hashing of the four key
// bytes (one byte per cycle), a restoring shift-and-subtract remainder over
// the 28 hash bits (one hash bit per cycle), then the chain access. An insert
// reads the chain head and the free-stack top and then links the new node in
// front of the chain; a lookup or delete reads the chain head and walks the
// chain, each node costing a read of the node memories and a compare, and one
// that misses ends with one more check of the end of the chain. Unknown
// operations and inserts into a full pool answer straight after the
// remainder, with no chain access. One request is in flight at a time:
// req_stall stays high from the accepted request until its response has been
// transferred. After reset the chain-head memory is cleared one entry per
// cycle with req_stall high. Nodes are taken from a stack of recycled nodes
// first and from never-used nodes after that. The bucket count register may
// be written at any time the block is idle; entries stored under an older
// bucket count stay where they were placed.
module int_key_chained_hash_table_core
   import ikht_pkg::*;
#(
   parameter int MAX_BUCKETS = 64,
   parameter int NODE_POOL   = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [31:0]       req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_value_out,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_bucket_count
);

   // Bucket index width, divisor width, node address and node pointer width.
   // A pointer equal to NODE_POOL marks the end of a chain.
   localparam int BIW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW  = $clog2(MAX_BUCKETS + 1);
   localparam int AW  = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
   localparam int NIW = $clog2(NODE_POOL + 1);
   localparam logic [NIW-1:0] NIL = NIW'(NODE_POOL);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_DIV, S_HEAD, S_INS, S_START, S_CHK, S_CMP, S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [1:0]       op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] key_sh_ff, key_sh_in;
   logic [31:0]      val_ff, val_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [BIW-1:0]   bucket_ff, bucket_in;
   logic [NIW-1:0]   cur_ff, cur_in;
   logic [NIW-1:0]   prev_ff, prev_in;
   logic [NIW-1:0]   steps_ff, steps_in;
   logic [NIW-1:0]   fresh_ff, fresh_in;
   logic [NIW-1:0]   sp_ff, sp_in;
   logic [NIW-1:0]   in_use_ff, in_use_in;
   logic [BIW-1:0]   clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_value_ff, rsp_value_in;

   // Memory ports.
   logic             head_we;
   logic [BIW-1:0]   head_waddr;
   logic [NIW-1:0]   head_wdata, head_rdata;
   logic             node_we;
   logic [AW-1:0]    node_waddr;
   logic [KEY_W-1:0] key_rdata;
   logic [31:0]      value_rdata;
   logic             next_we;
   logic [AW-1:0]    next_waddr;
   logic [NIW-1:0]   next_wdata, next_rdata;
   logic             stack_we;
   logic [AW-1:0]    stack_raddr;
   logic [AW-1:0]    stack_rdata;

   // Hash step and divisor helpers.
   logic [31:0]      byte_ext;
   logic [31:0]      hash_sum;
   logic [31:0]      hash_high;
   logic [31:0]      hash_step;
   logic [NW-1:0]    divisor;
   logic [NW:0]      rem_shift;
   logic [AW-1:0]    alloc_node;
   logic [NIW-1:0]   sp_dec;

   // The effective divisor: zero acts as one, anything above the bucket
   // capacity acts as the capacity.
   always_comb begin
      if (32'(cfg_ff) > 32'(MAX_BUCKETS)) begin
         divisor = NW'(MAX_BUCKETS);
      end else if (cfg_ff == '0) begin
         divisor = NW'(1);
      end else begin
         divisor = NW'(cfg_ff);
      end
   end

   // One ELF hash step on the lowest byte of the shifting key copy.
   assign byte_ext  = {{24{key_sh_ff[7]}}, key_sh_ff[7:0]};
   assign hash_sum  = {hash_ff, 4'b0000} + byte_ext;
   assign hash_high = hash_sum & ELF_HIGH_MASK;
   assign hash_step = (hash_sum ^ (hash_high >> ELF_FOLD_SHIFT)) & ~hash_high;

   // One restoring remainder step: bring in the next hash bit, most
   // significant first.
   assign rem_shift = {rem_ff, hash_ff[HASH_BITS-1]};

   // A recycled node is preferred; otherwise the next never-used node.
   assign alloc_node  = (sp_ff != '0) ? stack_rdata : fresh_ff[AW-1:0];
   assign sp_dec      = NIW'(sp_ff - NIW'(1));
   assign stack_raddr = sp_dec[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      cfg_in        = cfg_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      key_sh_in     = key_sh_ff;
      val_in        = val_ff;
      hash_in       = hash_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      fresh_in      = fresh_ff;
      sp_in         = sp_ff;
      in_use_in     = in_use_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = NIL;
      node_we       = 1'b0;
      node_waddr    = alloc_node;
      next_we       = 1'b0;
      next_waddr    = alloc_node;
      next_wdata    = head_rdata;
      stack_we      = 1'b0;

      if (csr_valid) begin
         cfg_in = csr_bucket_count;
      end

      case (state_ff)
         S_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            clr_in     = BIW'(clr_ff + BIW'(1));
            if (32'(clr_ff) == MAX_BUCKETS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               key_in    = req_key;
               key_sh_in = req_key;
               val_in    = req_value;
               hash_in   = '0;
               cnt_in    = '0;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            hash_in   = hash_step[HASH_BITS-1:0];
            key_sh_in = key_sh_ff >> 8;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_shift >= {1'b0, divisor}) begin
               rem_in = NW'(rem_shift - {1'b0, divisor});
            end else begin
               rem_in = rem_shift[NW-1:0];
            end
            hash_in = {hash_ff[HASH_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(HASH_BITS - 1)) begin
               bucket_in = rem_in[BIW-1:0];
               if (op_ff == OP_NONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_MISS;
                  rsp_value_in  = '0;
                  state_in      = S_RESP;
               end else if (op_ff == OP_INSERT && in_use_ff == NIL) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
                  rsp_value_in  = '0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            // Chain head and free stack top are read here.
            if (op_ff == OP_INSERT) begin
               state_in = S_INS;
            end else begin
               state_in = S_START;
            end
         end
         S_INS: begin
            node_we    = 1'b1;
            next_we    = 1'b1;
            head_we    = 1'b1;
            head_wdata = NIW'(alloc_node);
            if (sp_ff != '0) begin
               sp_in = NIW'(sp_ff - NIW'(1));
            end else begin
               fresh_in = NIW'(fresh_ff + NIW'(1));
            end
            in_use_in     = NIW'(in_use_ff + NIW'(1));
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = '0;
            state_in      = S_RESP;
         end
         S_START: begin
            cur_in   = head_rdata;
            prev_in  = NIL;
            steps_in = '0;
            state_in = S_CHK;
         end
         S_CHK: begin
            // Node memories are read at the current pointer here.
            if (cur_ff >= NIL || steps_ff == NIL) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISS;
               rsp_value_in  = '0;
               state_in      = S_RESP;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (key_rdata == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = '0;
               if (op_ff == OP_LOOKUP) begin
                  rsp_value_in = value_rdata;
               end else begin
                  // Unlink the node and return it to the free stack.
                  if (prev_ff == NIL) begin
                     head_we    = 1'b1;
                     head_wdata = next_rdata;
                  end else begin
                     next_we    = 1'b1;
                     next_waddr = prev_ff[AW-1:0];
                     next_wdata = next_rdata;
                  end
                  stack_we  = 1'b1;
                  sp_in     = NIW'(sp_ff + NIW'(1));
                  in_use_in = NIW'(in_use_ff - NIW'(1));
               end
               state_in = S_RESP;
            end else begin
               prev_in  = cur_ff;
               cur_in   = next_rdata;
               steps_in = NIW'(steps_ff + NIW'(1));
               state_in = S_CHK;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cfg_ff       <= BUCKET_COUNT_RESET;
         clr_ff       <= '0;
         fresh_ff     <= '0;
         sp_ff        <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         clr_ff       <= clr_in;
         fresh_ff     <= fresh_in;
         sp_ff        <= sp_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      key_sh_ff     <= key_sh_in;
      val_ff        <= val_in;
      hash_ff       <= hash_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   ikht_ram #(.WIDTH(NIW), .DEPTH(MAX_BUCKETS)) u_head (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (bucket_ff),
      .rd_data (head_rdata)
   );

   ikht_ram #(.WIDTH(KEY_W), .DEPTH(NODE_POOL)) u_node_key (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (key_ff),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (key_rdata)
   );

   ikht_ram #(.WIDTH(32), .DEPTH(NODE_POOL)) u_node_value (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (val_ff),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (value_rdata)
   );

   ikht_ram #(.WIDTH(NIW), .DEPTH(NODE_POOL)) u_node_next (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (next_rdata)
   );

   ikht_ram #(.WIDTH(AW), .DEPTH(NODE_POOL)) u_free_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (sp_ff[AW-1:0]),
      .wr_data (cur_ff[AW-1:0]),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign csr_ready     = 1'b1;

endmodule

// ===== sv/ikht_checker.sv =====
// Port-level checker for the hash table core, bound to the top level.
// Uses ikht_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module ikht_checker
   import ikht_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_value_out
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_value_out))
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_SAME(a_req_no_pending_rsp, clock, reset, req_valid && !req_stall, !rsp_valid)
   `ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_status != ST_RSVD)
   `ASSERT_SAME(a_zero_on_miss, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value_out == '0)

endmodule

bind int_key_chained_hash_table_core ikht_checker u_ikht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_value_out (rsp_value_out)
);

// ===== tb/tb_int_key_chained_hash_table_core.sv =====
// Self-checking testbench of the integer-key chained hash table core.
// Depends on ikht_pkg and int_key_chained_hash_table_core, which brings in ikht_ram.
`timescale 1ns / 100ps

module tb_int_key_chained_hash_table_core;
   import ikht_pkg::*;

   localparam int BUCKETS     = 64;
   localparam int POOL        = 256;
   localparam int NIL         = POOL;
   localparam int STALL_LIMIT = 6000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
   } answer_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_operation;
   logic [KEY_W-1:0]  req_key;
   logic [31:0]       req_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [31:0]       rsp_value_out;
   logic              csr_valid;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_bucket_count;

   int_key_chained_hash_table_core #(
      .MAX_BUCKETS(BUCKETS),
      .NODE_POOL  (POOL)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_bucket_count(csr_bucket_count)
   );

   // Shadow copy of the table. Node indexes chosen here need not match the
   // block's, since only the chain order is visible at the outputs.
   logic [6:0]  shadow_divisor;
   int          shadow_head  [BUCKETS];
   logic [31:0] shadow_key   [POOL];
   logic [31:0] shadow_value [POOL];
   int          shadow_next  [POOL];
   int          shadow_free  [POOL];
   int          shadow_top;

   answer_type  pending_answers[$];
   int          mismatches;
   int          failures;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          recv_hold;
   logic [31:0] key_pool[16];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [31:0] elf_hash(input logic [31:0] k);
      logic [31:0] h;
      logic [31:0] g;
      logic [31:0] b;
      h = '0;
      for (int i = 0; i < 4; i++) begin
         // Bytes are taken low first and sign-extended before they are added.
         b = {{24{k[8*i+7]}}, k[8*i +: 8]};
         h = (h << 4) + b;
         g = h & ELF_HIGH_MASK;
         if (g != 0) begin
            h = h ^ (g >> ELF_FOLD_SHIFT);
         end
         h = h & ~g;
      end
      return h;
   endfunction

   function automatic int bucket_of(input logic [31:0] k);
      int n;
      n = shadow_divisor;
      if (n == 0) n = 1;
      if (n > BUCKETS) n = BUCKETS;
      return elf_hash(k) % n;
   endfunction

   task automatic shadow_clear();
      shadow_divisor = BUCKET_COUNT_RESET;
      for (int i = 0; i < BUCKETS; i++) shadow_head[i] = NIL;
      for (int i = 0; i < POOL; i++) begin
         shadow_next[i] = NIL;
         shadow_free[i] = i;
      end
      shadow_top = 0;
   endtask

   // Applies one accepted operation to the shadow table and returns the answer.
   task automatic table_apply(input logic [1:0] op, input logic [31:0] k,
                              input logic [31:0] v, output answer_type ans);
      int b;
      int cur;
      int prev;
      int n;
      b = bucket_of(k);
      ans.status = ST_MISS;
      ans.value  = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_top >= POOL) begin
               ans.status = ST_FULL;
            end else begin
               n = shadow_free[shadow_top];
               shadow_top++;
               shadow_key[n]   = k;
               shadow_value[n] = v;
               shadow_next[n]  = shadow_head[b];
               shadow_head[b]  = n;
               ans.status = ST_OK;
            end
         end
         OP_LOOKUP, OP_DELETE: begin
            prev = NIL;
            cur  = shadow_head[b];
            for (int s = 0; s < POOL && cur < POOL; s++) begin
               if (shadow_key[cur] == k) begin
                  ans.status = ST_OK;
                  if (op == OP_LOOKUP) begin
                     ans.value = shadow_value[cur];
                  end else begin
                     if (prev == NIL) shadow_head[b] = shadow_next[cur];
                     else shadow_next[prev] = shadow_next[cur];
                     shadow_next[cur] = NIL;
                     if (shadow_top > 0) begin
                        shadow_top--;
                        shadow_free[shadow_top] = cur;
                     end
                  end
                  break;
               end
               prev = cur;
               cur  = shadow_next[cur];
            end
         end
         default: begin
         end
      endcase
   endtask

   // Sends one request after a random gap and predicts its answer at the
   // edge where the transfer happens.
   task automatic send_op(input logic [1:0] op, input logic [31:0] k,
                          input logic [31:0] v);
      answer_type ans;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= k;
      req_value     <= v;
      do @(posedge clock); while (req_stall);
      table_apply(op, k, v, ans);
      pending_answers.push_back(ans);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // The register is only written once every answer has come back.
   task automatic write_divisor(input logic [6:0] d);
      wait_drained();
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_bucket_count <= d;
      do @(posedge clock); while (!csr_ready);
      shadow_divisor = d;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(9) < 8) return key_pool[$urandom_range(15)];
      return $urandom;
   endfunction

   task automatic test_basic_ops();
      logic [31:0] edge_keys[4];
      edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      foreach (edge_keys[i]) send_op(OP_INSERT, edge_keys[i], ~(32'(i) * 32'h5555_5555));
      send_op(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      foreach (edge_keys[i]) send_op(OP_LOOKUP, edge_keys[i], $urandom);
      // A duplicate key shadows the older entry until it is deleted.
      send_op(OP_DELETE, 32'h0000_0000, '0);
      send_op(OP_LOOKUP, 32'h0000_0000, '0);
      send_op(OP_DELETE, 32'h1234_5678, '0);
      send_op(OP_LOOKUP, 32'h1234_5678, '0);
      send_op(OP_NONE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_LOOKUP, 32'h7FFF_FFFF, '0);
      foreach (edge_keys[i]) send_op(OP_DELETE, edge_keys[i], '0);
      send_op(OP_DELETE, 32'h8000_0000, '0);
   endtask

   task automatic test_divisor_range();
      logic [6:0] settings[5];
      settings = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd17};
      foreach (settings[i]) begin
         write_divisor(settings[i]);
         repeat (4) send_op(OP_INSERT, key_pool[$urandom_range(15)], $urandom);
         repeat (4) send_op(OP_LOOKUP, key_pool[$urandom_range(15)], '0);
      end
      // Entries stay in the chains they were placed in after a divisor change.
      write_divisor(7'd5);
      repeat (6) send_op(OP_LOOKUP, key_pool[$urandom_range(15)], '0);
      repeat (6) send_op(OP_DELETE, key_pool[$urandom_range(15)], '0);
   endtask

   task automatic test_pool_full();
      write_divisor(7'd64);
      while (shadow_top < POOL) send_op(OP_INSERT, $urandom, $urandom);
      repeat (3) send_op(OP_INSERT, key_pool[$urandom_range(15)], $urandom);
      repeat (40) send_op(OP_DELETE, pick_key(), '0);
      repeat (10) send_op(OP_INSERT, pick_key(), $urandom);
      // Empty the table so the random part starts with short chains. A chain
      // head placed under another divisor cannot be reached and stays.
      write_divisor(7'd1);
      while (shadow_top > 0 && shadow_head[0] != NIL)
         send_op(OP_DELETE, shadow_key[shadow_head[0]], '0);
      write_divisor(7'd64);
      for (int b = 0; b < BUCKETS; b++) begin
         while (shadow_head[b] != NIL && bucket_of(shadow_key[shadow_head[b]]) == b)
            send_op(OP_DELETE, shadow_key[shadow_head[b]], '0);
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      recv_hold = 300;
      repeat (5) send_op(OP_INSERT, pick_key(), $urandom);
      wait_drained();
      repeat (5) send_op(OP_LOOKUP, pick_key(), '0);
   endtask

   task automatic test_random(input int count);
      int r;
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            r = $urandom_range(3);
            write_divisor(r == 0 ? 7'd1 : r == 1 ? 7'd64 : 7'($urandom_range(127)));
         end
         r = $urandom_range(99);
         if (shadow_top > 200) op = (r < 70) ? OP_DELETE : OP_LOOKUP;
         else if (r < 40) op = OP_INSERT;
         else if (r < 72) op = OP_LOOKUP;
         else if (r < 95) op = OP_DELETE;
         else op = OP_NONE;
         send_op(op, pick_key(), $urandom);
      end
   endtask

   // Receiver: random stalls, or a long counted hold when one is requested.
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         rsp_stall <= 1'b1;
         recv_hold <= recv_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Answer checker and watchdog.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            failures++;
            if (mismatches < 10) $display("Unexpected response: status %0d value %h",
                                          rsp_status, rsp_value_out);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_value_out !== want.value) begin
               failures++;
               if (mismatches < 10)
                  $display("Mismatch: expected status %0d value %h, got status %0d value %h",
                           want.status, want.value, rsp_status, rsp_value_out);
               mismatches++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_valid        = 1'b0;
      req_operation    = OP_INSERT;
      req_key          = '0;
      req_value        = '0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_bucket_count = '0;
      mismatches       = 0;
      failures         = 0;
      idle_cycles      = 0;
      recv_hold        = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0080;
      key_pool[1] = 32'hFFFF_FF7F;
      shadow_clear();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_divisor_range();
      test_backpressure();
      test_pool_full();
      send_idle_pct = 25;
      recv_idle_pct = 84;
      test_random(110);
      send_idle_pct = 84;
      recv_idle_pct = 25;
      test_random(110);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(115);

      wait_drained();
      repeat (600) @(posedge clock);
      failures = failures + pending_answers.size();
      if (failures == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
